/* rtl/core/ldr_pkg.sv */
// shared constants, register codes and the pipeline item type for the
// logistic dose-response evaluator; no dependencies
package ldr_pkg;

	localparam int CONC_W  = 32;
	localparam int VIA_W   = 17;
	localparam int LVL_W   = 7;
	localparam int MID_W   = 24;
	localparam int SCALE_W = 24;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;
	localparam int FRAC    = 16;
	localparam int Q_BITS  = 30;
	localparam int LOG_W   = 5 + FRAC;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	localparam logic [CONC_W-1:0]  TOP_DOSE_RST = 32'd65536;
	localparam logic [MID_W-1:0]   MID_RST      = 24'd589824;
	localparam logic [SCALE_W-1:0] SCALE_RST    = 24'd65536;
	localparam logic [LVL_W-1:0]   LEVEL_RST    = 7'd5;

	typedef enum logic [1:0] {
		REG_TOP_DOSE    = 2'd0,
		REG_MID_POINT   = 2'd1,
		REG_SLOPE_SCALE = 2'd2,
		REG_LEVEL_COUNT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               valid;
		logic               mode;
		logic               czero;
		logic [10:0]        num;
		logic [10:0]        den;
		logic signed [21:0] da;
		logic signed [24:0] diff;
		logic               neg0;
		logic [40:0]        mnum;
		logic               neg1;
		logic [50:0]        prod1;
		logic [20:0]        lnw;
		logic [44:0]        prod2;
		logic signed [29:0] e;
		logic [52:0]        produ;
		logic               big;
		logic [4:0]         ipu;
		logic [15:0]        fru;
		logic [63:0]        dd;
		logic [63:0]        prod;
		logic [31:0]        conc;
		logic               sat;
	} item_t;

endpackage

/* rtl/core/ldr_if.sv */
// stream channels of the dose-response evaluator: request and result beats
// depends on ldr_pkg
interface ldr_in_if;
	import ldr_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [CONC_W-1:0] concentration;
	logic [LVL_W-1:0]  level;
	modport source(output valid, action, concentration, level, input ready);
	modport sink(input valid, action, concentration, level, output ready);
endinterface

interface ldr_out_if;
	import ldr_pkg::*;
	logic              valid;
	logic              ready;
	logic [VIA_W-1:0]  viability;
	logic [CONC_W-1:0] concentration_out;
	logic              saturated;
	modport source(output valid, viability, concentration_out, saturated, input ready);
	modport sink(input valid, viability, concentration_out, saturated, output ready);
endinterface

/* rtl/core/ldr_log2.sv */
// dual pipelined log2 unit: normalise, then one squaring per stage
// depends on ldr_pkg
module ldr_log2 #(
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [ldr_pkg::CONC_W-1:0] a,
	input  logic [ldr_pkg::CONC_W-1:0] b,
	input  logic [SW-1:0]              side_in,
	output logic [ldr_pkg::LOG_W-1:0]  la,
	output logic [ldr_pkg::LOG_W-1:0]  lb,
	output logic [SW-1:0]              side_out
);
	import ldr_pkg::*;

	localparam int PW = $clog2(CONC_W);
	localparam int MW = Q_BITS + 1;

	function automatic logic [PW-1:0] msb_pos(logic [CONC_W-1:0] v);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < CONC_W; i++) begin
			if (v[i]) p = PW'(i);
		end
		return p;
	endfunction

	logic [CONC_W-1:0] op [2];
	logic [PW-1:0]     p_s [FRAC+1][2];
	logic [MW-1:0]     m_s [FRAC+1][2];
	logic [FRAC-1:0]   f_s [FRAC+1][2];
	logic [SW-1:0]     side_s [FRAC+1];

	assign op[0] = a;
	assign op[1] = b;

	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		logic [PW-1:0]            p0;
		logic [CONC_W+Q_BITS-1:0] wide;
		assign p0   = msb_pos(op[ln]);
		assign wide = {op[ln], {Q_BITS{1'b0}}} >> p0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				p_s[0][ln] <= '0;
				m_s[0][ln] <= '0;
				f_s[0][ln] <= '0;
			end else if (en) begin
				p_s[0][ln] <= p0;
				m_s[0][ln] <= wide[MW-1:0];
				f_s[0][ln] <= '0;
			end
		end

		for (genvar g = 0; g < FRAC; g++) begin : g_sq
			logic [2*MW-1:0] sq;
			logic [MW:0]     t;
			assign sq = (2*MW)'(m_s[g][ln]) * (2*MW)'(m_s[g][ln]);
			assign t  = sq[Q_BITS +: MW+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					p_s[g+1][ln] <= '0;
					m_s[g+1][ln] <= '0;
					f_s[g+1][ln] <= '0;
				end else if (en) begin
					p_s[g+1][ln] <= p_s[g][ln];
					m_s[g+1][ln] <= t[MW] ? t[MW:1] : t[MW-1:0];
					f_s[g+1][ln] <= {f_s[g][ln][FRAC-2:0], t[MW]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else if (en) begin
			side_s[0] <= side_in;
		end
	end

	for (genvar g = 0; g < FRAC; g++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g+1] <= '0;
			end else if (en) begin
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign la       = {p_s[FRAC][0], f_s[FRAC][0]};
	assign lb       = {p_s[FRAC][1], f_s[FRAC][1]};
	assign side_out = side_s[FRAC];

endmodule

/* rtl/core/ldr_div.sv */
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// no dependencies; ldr_pkg is not imported
module ldr_div #(
	parameter int NW = 41,
	parameter int DW = 24,
	parameter int QW = 23,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] side_out
);
	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [CW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic          ovf_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign rem_s[0]  = CW'(num);
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign ovf_s[0]  = CW'(num) >= (CW'(den) << QW);
	assign side_s[0] = side_in;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;
		logic [CW-1:0] trial;
		logic          take;
		assign trial = CW'(den_s[g]) << B;
		assign take  = rem_s[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_s[g+1]  <= '0;
				den_s[g+1]  <= '0;
				quo_s[g+1]  <= '0;
				ovf_s[g+1]  <= 1'b0;
				side_s[g+1] <= '0;
			end else if (en) begin
				rem_s[g+1]  <= take ? rem_s[g] - trial : rem_s[g];
				den_s[g+1]  <= den_s[g];
				quo_s[g+1]  <= quo_s[g] | (QW'(take) << B);
				ovf_s[g+1]  <= ovf_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign quo      = quo_s[QW];
	assign ovf      = ovf_s[QW];
	assign side_out = side_s[QW];

endmodule

/* rtl/core/logistic_dose_response_eval.sv */
// top level of the logistic dose-response evaluator: config registers and pipeline
// depends on ldr_pkg, ldr_if, ldr_log2, ldr_div
//
//  channel   dir   beat contents                                   handshake
//  dose_in   in    action, concentration, level                    valid/ready
//  dose_out  out   viability, concentration_out, saturated         valid/ready
//  apb       in    top_dose, mid_point, slope_scale, level_count   psel/penable
//
// one beat per cycle sustained while no result is stalled at the output
// the pipeline is built around the 23-stage slope divider, the 17-stage final divider,
// the log2 chain and the 16-stage exp2 chain
// reset clears all valid bits and loads the register defaults
// a result waiting at the output freezes the whole pipeline, nothing is lost
module logistic_dose_response_eval (
	input  logic                       clk,
	input  logic                       arst_n,
	ldr_in_if.sink                     dose_in,
	ldr_out_if.source                  dose_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ldr_pkg::ADDR_W-1:0] paddr,
	input  logic [ldr_pkg::DATA_W-1:0] pwdata,
	output logic [ldr_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import ldr_pkg::*;

	localparam int IW = $bits(item_t);

	function automatic logic [63:0] isqrt64(logic [63:0] v0);
		logic [63:0] v, r, b;
		v = v0;
		r = '0;
		b = 64'h1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] exp2_root(int k);
		logic [63:0] c;
		c = 64'h2 << Q_BITS;
		for (int j = 0; j < k; j++) begin
			c = isqrt64(c << Q_BITS);
		end
		return c;
	endfunction

	// configuration
	logic [CONC_W-1:0]  top_dose_q;
	logic [MID_W-1:0]   mid_point_q;
	logic [SCALE_W-1:0] slope_scale_q;
	logic [LVL_W-1:0]   level_count_q;
	cfg_reg_t           cfg_sel;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_dose_q    <= TOP_DOSE_RST;
			mid_point_q   <= MID_RST;
			slope_scale_q <= SCALE_RST;
			level_count_q <= LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_TOP_DOSE:    top_dose_q    <= pwdata[CONC_W-1:0];
				REG_MID_POINT:   mid_point_q   <= pwdata[MID_W-1:0];
				REG_SLOPE_SCALE: slope_scale_q <= pwdata[SCALE_W-1:0];
				REG_LEVEL_COUNT: level_count_q <= pwdata[LVL_W-1:0];
				default:         top_dose_q    <= top_dose_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_TOP_DOSE:    prdata = DATA_W'(top_dose_q);
			REG_MID_POINT:   prdata = DATA_W'(mid_point_q);
			REG_SLOPE_SCALE: prdata = DATA_W'(slope_scale_q);
			REG_LEVEL_COUNT: prdata = DATA_W'(level_count_q);
			default:         prdata = '0;
		endcase
	end

	logic [CONC_W-1:0]  mc;
	logic [SCALE_W-1:0] sc;
	logic [MID_W:0]     mid25;
	assign mc    = (top_dose_q == '0) ? CONC_W'(1) : top_dose_q;
	assign sc    = (slope_scale_q == '0) ? SCALE_W'(1) : slope_scale_q;
	assign mid25 = {mid_point_q[MID_W-1], mid_point_q};

	// pipeline advance
	logic en;
	logic out_valid_q;
	assign en            = !out_valid_q || dose_out.ready;
	assign dose_in.ready = en;

	// s1: level arithmetic and log2 operand selection
	item_t             s1_d, s1_s;
	logic [CONC_W-1:0] a_d, b_d, a_s1, b_s1;
	logic [LVL_W-1:0]  lc, lv, lcm, lvm;

	always_comb begin
		lc = (level_count_q < LVL_W'(2)) ? LVL_W'(2) : level_count_q;
		lv = dose_in.level;
		if (lv == '0) lv = LVL_W'(1);
		if (lv > lc) lv = lc;
		lcm = lc - LVL_W'(1);
		lvm = lv - LVL_W'(1);
		s1_d       = '0;
		s1_d.valid = dose_in.valid;
		s1_d.mode  = dose_in.action;
		s1_d.czero = dose_in.concentration == '0;
		s1_d.num   = 11'(lcm) * 11'd9 - 11'(lvm) * 11'd8;
		s1_d.den   = 11'(lcm) * 11'd10;
		if (dose_in.action) begin
			a_d = CONC_W'(s1_d.den - s1_d.num);
			b_d = CONC_W'(s1_d.num);
		end else begin
			a_d = s1_d.czero ? CONC_W'(1) : dose_in.concentration;
			b_d = mc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s <= '0;
			a_s1 <= '0;
			b_s1 <= '0;
		end else if (en) begin
			s1_s <= s1_d;
			a_s1 <= a_d;
			b_s1 <= b_d;
		end
	end

	logic [LOG_W-1:0] la, lb;
	logic [IW-1:0]    lg_side;
	item_t            lg_item;

	ldr_log2 #(.SW(IW)) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.a        (a_s1),
		.b        (b_s1),
		.side_in  (s1_s),
		.la       (la),
		.lb       (lb),
		.side_out (lg_side)
	);
	assign lg_item = lg_side;

	// c1..c5: log difference, slope numerator, and the inverse curve
	item_t c1_d, c2_d, c3_d, c4_d, c5_d;
	item_t c1_s, c2_s, c3_s, c4_s, c5_s;
	logic [20:0] da_mag;
	logic [23:0] diff_mag;
	logic [29:0] xr;
	logic [29:0] xs;

	always_comb begin
		c1_d    = lg_item;
		c1_d.da = $signed({1'b0, la}) - $signed({1'b0, lb});
	end

	always_comb begin
		c2_d       = c1_s;
		da_mag     = c1_s.da[21] ? 21'(-c1_s.da) : 21'(c1_s.da);
		c2_d.diff  = $signed({{3{c1_s.da[21]}}, c1_s.da}) + 25'sd589824 - $signed(mid25);
		c2_d.neg1  = c1_s.da[21];
		c2_d.prod1 = 51'(da_mag) * 51'(LN2_Q30);
	end

	always_comb begin
		c3_d      = c2_s;
		diff_mag  = c2_s.diff[24] ? 24'(-c2_s.diff) : 24'(c2_s.diff);
		c3_d.neg0 = c2_s.diff[24];
		c3_d.mnum = {1'b0, diff_mag, {FRAC{1'b0}}} + 41'(sc >> 1);
		c3_d.lnw  = 21'((c2_s.prod1 + (51'd1 << (Q_BITS - 1))) >> Q_BITS);
	end

	always_comb begin
		c4_d       = c3_s;
		c4_d.prod2 = 45'(c3_s.lnw) * 45'(sc);
	end

	always_comb begin
		c5_d   = c4_s;
		xr     = 30'((46'(c4_s.prod2) + 46'd32768) >> FRAC);
		xs     = c4_s.neg1 ? -xr : xr;
		c5_d.e = $signed(xs) + $signed({{5{mid25[MID_W]}}, mid25}) - 30'sd589824;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_s <= '0;
			c2_s <= '0;
			c3_s <= '0;
			c4_s <= '0;
			c5_s <= '0;
		end else if (en) begin
			c1_s <= c1_d;
			c2_s <= c2_d;
			c3_s <= c3_d;
			c4_s <= c4_d;
			c5_s <= c5_d;
		end
	end

	// slope division, quotient clamped to the exponent limit
	logic [22:0]   tq;
	logic          tovf;
	logic [IW-1:0] td_side;
	item_t         td_item;

	ldr_div #(.NW(41), .DW(SCALE_W), .QW(23), .SW(IW)) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.num      (c5_s.mnum),
		.den      (sc),
		.side_in  (c5_s),
		.quo      (tq),
		.ovf      (tovf),
		.side_out (td_side)
	);
	assign td_item = td_side;

	item_t       u1_d, u2_d, u1_s, u2_s;
	logic [22:0] tm;
	logic [22:0] um;

	always_comb begin
		u1_d       = td_item;
		tm         = (tovf || tq > 23'd4194304) ? 23'd4194304 : tq;
		u1_d.produ = 53'(tm) * 53'(LOG2E_Q30);
	end

	always_comb begin
		u2_d     = u1_s;
		um       = 23'((u1_s.produ + (53'd1 << (Q_BITS - 1))) >> Q_BITS);
		u2_d.big = um[22:21] != 2'b00;
		u2_d.ipu = um[20:16];
		u2_d.fru = um[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u1_s <= '0;
			u2_s <= '0;
		end else if (en) begin
			u1_s <= u1_d;
			u2_s <= u2_d;
		end
	end

	// exp2 of the fraction: one root factor per stage
	item_t           ex_s [FRAC+1];
	logic [31:0]     ex_r [FRAC+1];
	logic [FRAC-1:0] ex_f [FRAC+1];

	assign ex_s[0] = u2_s;
	assign ex_r[0] = 32'd1 << Q_BITS;
	assign ex_f[0] = u2_s.mode ? u2_s.e[FRAC-1:0] : u2_s.fru;

	for (genvar g = 0; g < FRAC; g++) begin : g_exp
		localparam logic [63:0] CK64 = exp2_root(g + 1);
		localparam logic [31:0] CK   = CK64[31:0];
		logic [63:0] pr;
		assign pr = (64'(ex_r[g]) * 64'(CK) + (64'd1 << (Q_BITS - 1))) >> Q_BITS;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_s[g+1] <= '0;
				ex_r[g+1] <= '0;
				ex_f[g+1] <= '0;
			end else if (en) begin
				ex_s[g+1] <= ex_s[g];
				ex_r[g+1] <= ex_f[g][FRAC-1-g] ? pr[31:0] : ex_r[g];
				ex_f[g+1] <= ex_f[g];
			end
		end
	end

	// f1: logistic denominator and scaled concentration product
	item_t f1_d, f1_s, f2_d, f2_s;
	always_comb begin
		f1_d      = ex_s[FRAC];
		f1_d.dd   = (64'd1 << Q_BITS) + (64'(ex_r[FRAC]) << ex_s[FRAC].ipu);
		f1_d.prod = 64'(mc) * 64'(ex_r[FRAC]);
	end

	// f2: concentration shift and final division operands
	logic signed [13:0] ip;
	logic signed [14:0] sh_full;
	logic [5:0]         shv;
	logic [63:0]        c64;
	logic               sat;
	logic [63:0]        fn_d, fd_d, fn_s, fd_s;

	always_comb begin
		f2_d    = f1_s;
		ip      = f1_s.e[29:16];
		sh_full = 15'sd30 - 15'(ip);
		shv     = sh_full[5:0];
		c64     = '0;
		sat     = 1'b0;
		if (ip >= 14'sd32) begin
			sat = 1'b1;
		end else if (ip <= -14'sd33) begin
			c64 = '0;
		end else if (ip <= 14'sd29) begin
			c64 = (f1_s.prod + (64'd1 << (shv - 6'd1))) >> shv;
		end else if (ip == 14'sd30) begin
			c64 = f1_s.prod;
		end else begin
			if (f1_s.prod > 64'h7FFF_FFFF) sat = 1'b1;
			else c64 = f1_s.prod << 1;
		end
		if (c64 > 64'hFFFF_FFFF) sat = 1'b1;
		f2_d.sat  = f1_s.mode && sat;
		f2_d.conc = !f1_s.mode ? '0 : (sat ? 32'hFFFF_FFFF : c64[31:0]);
		if (f1_s.mode) begin
			fn_d = {37'd0, f1_s.num, 16'd0} + 64'(f1_s.den >> 1);
			fd_d = 64'(f1_s.den);
		end else begin
			fn_d = (64'd1 << (Q_BITS + FRAC)) + (f1_s.dd >> 1);
			fd_d = f1_s.dd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_s <= '0;
			f2_s <= '0;
			fn_s <= '0;
			fd_s <= '0;
		end else if (en) begin
			f1_s <= f1_d;
			f2_s <= f2_d;
			fn_s <= fn_d;
			fd_s <= fd_d;
		end
	end

	logic [16:0]   vq;
	logic          vovf;
	logic [IW-1:0] vd_side;
	item_t         vd_item;

	ldr_div #(.NW(64), .DW(64), .QW(17), .SW(IW)) u_vdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.num      (fn_s),
		.den      (fd_s),
		.side_in  (f2_s),
		.quo      (vq),
		.ovf      (vovf),
		.side_out (vd_side)
	);
	assign vd_item = vd_side;

	// output register
	logic [VIA_W-1:0]  via_d, via_q;
	logic [CONC_W-1:0] conc_q;
	logic              sat_q;

	always_comb begin
		if (vd_item.mode || vovf) via_d = vq;
		else if (vd_item.czero) via_d = 17'd65536;
		else if (vd_item.big) via_d = vd_item.neg0 ? 17'd65536 : 17'd0;
		else if (vd_item.neg0) via_d = 17'd65536 - vq;
		else via_d = vq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			via_q       <= '0;
			conc_q      <= '0;
			sat_q       <= 1'b0;
		end else if (en) begin
			out_valid_q <= vd_item.valid;
			via_q       <= via_d;
			conc_q      <= vd_item.conc;
			sat_q       <= vd_item.sat;
		end
	end

	assign dose_out.valid             = out_valid_q;
	assign dose_out.viability         = via_q;
	assign dose_out.concentration_out = conc_q;
	assign dose_out.saturated         = sat_q;

endmodule

/* rtl/core/ldr_checker.sv */
// port-level checks for the dose-response evaluator, bound to the top level
// depends on logistic_dose_response_eval ports
module ldr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] via,
	input logic [31:0] conc,
	input logic        sat
);

	// held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(via) && $stable(conc) && $stable(sat))
		else $error("result beat changed while stalled");

	// a stalled result blocks new requests
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sat |-> conc == 32'hFFFF_FFFF && via <= 17'd65536)
		else $error("saturated beat without full scale");

endmodule

bind logistic_dose_response_eval ldr_checker u_ldr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (dose_in.valid),
	.in_ready  (dose_in.ready),
	.out_valid (dose_out.valid),
	.out_ready (dose_out.ready),
	.via       (dose_out.viability),
	.conc      (dose_out.concentration_out),
	.sat       (dose_out.saturated)
);
